### design/sefx_pkg.sv
`default_nettype none

package sefx_pkg;

	localparam int SEFX_BUFFER_BYTES = 64;

	localparam logic [7:0] START_MARK = 8'h02;
	localparam logic [7:0] END_MARK   = 8'h03;

	localparam int LEN_W = 16;
	localparam int END_W = 17;
	localparam int PAY_W = 6;

	// First payload byte sits this far past the start marker.
	localparam int PAY_OFS = 6;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_SCAN   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
	} rx_req_t;

	typedef struct packed {
		logic [15:0]      packet_number;
		logic [7:0]       command;
		logic [PAY_W-1:0] payload_length;
		logic             has_data;
		logic [7:0]       data_byte;
		logic             last;
	} frame_res_t;

	typedef enum logic [2:0] {
		RA_IDX,
		RA_PN_LO,
		RA_PN_HI,
		RA_CMD,
		RA_LEN_LO,
		RA_LEN_HI,
		RA_END,
		RA_DATA
	} rd_sel_t;

	typedef enum logic [2:0] {
		DROP_NONE,
		DROP_ALL,
		DROP_HEAD,
		DROP_PAST_HEAD,
		DROP_FRAME
	} drop_t;

	typedef struct packed {
		logic    append;
		drop_t   drop;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    idx_clr;
		logic    idx_inc;
		logic    len_lo_ld;
		logic    len_hi_ld;
		logic    pn_lo_ld;
		logic    pn_hi_ld;
		logic    cmd_ld;
		logic    k_clr;
		logic    k_inc;
		logic    out_ld;
	} sefx_cmd_t;

	typedef struct packed {
		logic idx_end;
		logic is_start;
		logic hdr_short;
		logic frame_short;
		logic is_end;
		logic out_taken;
		logic out_last;
	} sefx_stat_t;

endpackage

`default_nettype wire

### design/sefx_if.sv
`default_nettype none

interface sefx_rx_if import sefx_pkg::*; ();
	logic    valid;
	logic    ready;
	rx_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sefx_frame_if import sefx_pkg::*; ();
	logic       valid;
	logic       ready;
	frame_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/stx_etx_length_frame_extractor_unit.sv
// channel | dir | payload                                              | handshake
// rx      | in  | mode, rx_byte                                        | valid/ready
// frames  | out | packet_number, command, payload_length, has_data,    | valid/ready
//         |     | data_byte, last                                      |
//
// One request at a time. A clear empties the store; otherwise the scan reads the bytes
// ahead of the start marker one by one, then the header and end marker, and each
// result waits out any stall on frames. The byte memory has a single read port, which
// serializes these reads. Reset empties the store at once, with no clearing pass.
`default_nettype none

module stx_etx_length_frame_extractor_unit import sefx_pkg::*; #(
	parameter int BUFFER_BYTES = SEFX_BUFFER_BYTES
) (
	input  logic          clk,
	input  logic          arst_n,
	sefx_rx_if.sink       rx,
	sefx_frame_if.source  frames
);

	sefx_cmd_t  cmd;
	sefx_stat_t stat;
	logic       in_ready;
	logic       out_valid;
	frame_res_t out_data;

	sefx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.mode     (rx.data.mode),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sefx_datapath #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rx_byte   (rx.data.rx_byte),
		.out_ready (frames.ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.stat      (stat)
	);

	assign rx.ready     = in_ready;
	assign frames.valid = out_valid;
	assign frames.data  = out_data;

endmodule

`default_nettype wire

### design/sefx_ctrl.sv
`default_nettype none

module sefx_ctrl import sefx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] mode,
	output logic       in_ready,
	input  sefx_stat_t stat,
	output sefx_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CK,
		S_LEN_LO,
		S_LEN_HI,
		S_END_RD,
		S_END_CK,
		S_PN_LO,
		S_PN_HI,
		S_CMD,
		S_DATA_RD,
		S_DATA_LD,
		S_WAIT_OUT
	} state_t;

	state_t state_q, state_d;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready_q) begin
					case (mode)
						MODE_CLEAR: begin
							cmd.drop = DROP_ALL;
						end
						MODE_APPEND: begin
							cmd.append  = 1'b1;
							cmd.idx_clr = 1'b1;
							state_d     = S_SCAN_RD;
						end
						default: begin
							cmd.idx_clr = 1'b1;
							state_d     = S_SCAN_RD;
						end
					endcase
				end
			end
			S_SCAN_RD: begin
				if (stat.idx_end) begin
					cmd.drop = DROP_ALL;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX;
					state_d    = S_SCAN_CK;
				end
			end
			S_SCAN_CK: begin
				if (!stat.is_start) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end else if (stat.hdr_short) begin
					cmd.drop = DROP_HEAD;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_LEN_LO;
					state_d    = S_LEN_LO;
				end
			end
			S_LEN_LO: begin
				cmd.len_lo_ld = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RA_LEN_HI;
				state_d       = S_LEN_HI;
			end
			S_LEN_HI: begin
				cmd.len_hi_ld = 1'b1;
				state_d       = S_END_RD;
			end
			S_END_RD: begin
				if (stat.frame_short) begin
					cmd.drop = DROP_HEAD;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_END;
					state_d    = S_END_CK;
				end
			end
			S_END_CK: begin
				if (!stat.is_end) begin
					cmd.drop = DROP_PAST_HEAD;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PN_LO;
					state_d    = S_PN_LO;
				end
			end
			S_PN_LO: begin
				cmd.pn_lo_ld = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RA_PN_HI;
				state_d      = S_PN_HI;
			end
			S_PN_HI: begin
				cmd.pn_hi_ld = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RA_CMD;
				state_d      = S_CMD;
			end
			S_CMD: begin
				cmd.cmd_ld = 1'b1;
				cmd.k_clr  = 1'b1;
				state_d    = S_DATA_RD;
			end
			S_DATA_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_DATA;
				state_d    = S_DATA_LD;
			end
			S_DATA_LD: begin
				cmd.out_ld = 1'b1;
				state_d    = S_WAIT_OUT;
			end
			S_WAIT_OUT: begin
				if (stat.out_taken) begin
					if (stat.out_last) begin
						cmd.drop = DROP_FRAME;
						state_d  = S_IDLE;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = S_DATA_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			in_ready_q <= (state_d == S_IDLE);
		end
	end

endmodule

`default_nettype wire

### design/sefx_datapath.sv
`default_nettype none

module sefx_datapath import sefx_pkg::*; #(
	parameter int BUFFER_BYTES = SEFX_BUFFER_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  sefx_cmd_t  cmd,
	input  logic [7:0] rx_byte,
	input  logic       out_ready,
	output logic       out_valid,
	output frame_res_t out_data,
	output sefx_stat_t stat
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int OW = AW + 1;

	// circular store: logical entry 0 lives at base_q
	logic [7:0]       store_mem [BUFFER_BYTES];
	logic [AW-1:0]    base_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    idx_q;
	logic [7:0]       rdata_q;
	logic [7:0]       len_lo_q;
	logic [LEN_W-1:0] len_q;
	logic [END_W-1:0] endpos_q;
	logic [15:0]      pn_q;
	logic [7:0]       cmd_q;
	logic [PAY_W-1:0] k_q;
	logic             out_valid_q;
	frame_res_t       out_q;

	logic [OW-1:0]    rd_off;
	logic [OW-1:0]    wr_off;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [END_W-1:0] drop_n;
	logic             len_zero;
	logic             k_last;
	logic             out_taken;

	function automatic logic [AW-1:0] wrap(input logic [OW-1:0] s);
		return (s >= OW'(BUFFER_BYTES)) ? AW'(s - OW'(BUFFER_BYTES)) : AW'(s);
	endfunction

	always_comb begin
		case (cmd.rd_sel)
			RA_IDX:    rd_off = OW'(idx_q);
			RA_PN_LO:  rd_off = OW'(idx_q) + OW'(1);
			RA_PN_HI:  rd_off = OW'(idx_q) + OW'(2);
			RA_CMD:    rd_off = OW'(idx_q) + OW'(3);
			RA_LEN_LO: rd_off = OW'(idx_q) + OW'(4);
			RA_LEN_HI: rd_off = OW'(idx_q) + OW'(5);
			RA_END:    rd_off = endpos_q[OW-1:0];
			RA_DATA:   rd_off = OW'(idx_q) + OW'(PAY_OFS) + OW'(k_q);
			default:   rd_off = '0;
		endcase
	end

	assign wr_off  = (fill_q == CW'(BUFFER_BYTES)) ? '0 : OW'(fill_q);
	assign rd_addr = wrap(OW'(base_q) + rd_off);
	assign wr_addr = wrap(OW'(base_q) + wr_off);

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			store_mem[wr_addr] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rdata_q <= store_mem[rd_addr];
		end
	end

	always_comb begin
		unique case (cmd.drop)
			DROP_HEAD:      drop_n = END_W'(idx_q);
			DROP_PAST_HEAD: drop_n = END_W'(idx_q) + END_W'(1);
			DROP_FRAME:     drop_n = endpos_q + END_W'(1);
			default:        drop_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			fill_q <= '0;
		end else if (cmd.append) begin
			fill_q <= (fill_q == CW'(BUFFER_BYTES)) ? CW'(1) : fill_q + CW'(1);
		end else if (cmd.drop == DROP_ALL) begin
			fill_q <= '0;
		end else if (cmd.drop != DROP_NONE) begin
			if (drop_n >= END_W'(fill_q)) begin
				fill_q <= '0;
			end else begin
				base_q <= wrap(OW'(base_q) + drop_n[OW-1:0]);
				fill_q <= fill_q - drop_n[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.len_lo_ld) begin
			len_lo_q <= rdata_q;
		end
		if (cmd.len_hi_ld) begin
			len_q    <= {rdata_q, len_lo_q};
			endpos_q <= END_W'(idx_q) + END_W'(PAY_OFS) + END_W'({rdata_q, len_lo_q});
		end
		if (cmd.pn_lo_ld) begin
			pn_q[7:0] <= rdata_q;
		end
		if (cmd.pn_hi_ld) begin
			pn_q[15:8] <= rdata_q;
		end
		if (cmd.cmd_ld) begin
			cmd_q <= rdata_q;
		end
		if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + PAY_W'(1);
		end
	end

	assign len_zero  = (len_q == '0);
	assign k_last    = len_zero || (({1'b0, k_q} + 7'd1) == {1'b0, len_q[PAY_W-1:0]});
	assign out_taken = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_taken) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_q.packet_number  <= pn_q;
			out_q.command        <= cmd_q;
			out_q.payload_length <= len_q[PAY_W-1:0];
			out_q.has_data       <= !len_zero;
			out_q.data_byte      <= len_zero ? 8'h00 : rdata_q;
			out_q.last           <= k_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.idx_end     = (idx_q >= fill_q);
	assign stat.is_start    = (rdata_q == START_MARK);
	assign stat.hdr_short   = (END_W'(fill_q) <= END_W'(idx_q) + END_W'(PAY_OFS));
	assign stat.frame_short = (END_W'(fill_q) <= endpos_q);
	assign stat.is_end      = (rdata_q == END_MARK);
	assign stat.out_taken   = out_taken;
	assign stat.out_last    = out_q.last;

endmodule

`default_nettype wire
